/* rtl/core/sfr_pkg.sv */
// Shared types, codes, constants and the angle check of the sensor frame receiver.
package sfr_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int QUEUE_DEPTH = 2;
    // Bytes 0 to 14 of a frame are the only ones that are ever inspected.
    localparam int FRAME_BYTES = 15;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOOTER  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 3'd4;

    localparam logic [7:0]  RESET_HEADER  = 8'hFE;
    localparam logic [7:0]  RESET_FOOTER  = 8'hFF;
    localparam logic [15:0] RESET_FIRST   = 16'h2025;
    localparam logic [15:0] RESET_SECOND  = 16'h2026;
    localparam logic [31:0] RESET_TIMEOUT = 32'd1000;

    localparam logic [7:0]  LEN_CODE     = 8'd13;
    localparam logic [30:0] EXP_ALL_ONES = 31'h7F80_0000;
    localparam logic [30:0] MAG_360      = 31'h43B4_0000;
    localparam logic [30:0] MAG_MILLI    = 31'h3A83_126F;

    localparam logic [1:0] ST_NONE       = 2'd0;
    localparam logic [1:0] ST_ACCEPT     = 2'd1;
    localparam logic [1:0] ST_VALUE_FAIL = 2'd2;
    localparam logic [1:0] ST_DROP       = 2'd3;

    localparam logic [1:0] SLOT_0    = 2'd0;
    localparam logic [1:0] SLOT_1    = 2'd1;
    localparam logic [1:0] SLOT_NONE = 2'd2;

    localparam logic [2:0] CMD_BYTE    = 3'd0;
    localparam logic [2:0] CMD_DROP    = 3'd1;
    localparam logic [2:0] CMD_REJECT  = 3'd2;
    localparam logic [2:0] CMD_ACCEPT  = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT = 3'd4;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  footer_byte;
        logic [15:0] first_slot_address;
        logic [15:0] second_slot_address;
        logic [31:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] sensor_address;
        logic [31:0] pitch_bits;
        logic [31:0] roll_bits;
        logic [7:0]  range_value;
        logic [31:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // NaN, infinity, above 360 and nonzero below one thousandth all fail.
    function automatic logic angle_ok(input logic [31:0] bits);
        logic [30:0] mag;
        mag = bits[30:0];
        return (mag < EXP_ALL_ONES) && (mag <= MAG_360)
            && ((mag == 31'd0) || (mag >= MAG_MILLI));
    endfunction

endpackage

/* rtl/core/sfr_if.sv */
// Handshake channels for incoming words and result words.
interface sfr_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;

    modport source (output valid, action, rx_byte, now_ms, input ready);
    modport sink (input valid, action, rx_byte, now_ms, output ready);
endinterface

interface sfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] sensor_address;
    logic [31:0] pitch_bits;
    logic [31:0] roll_bits;
    logic [7:0]  range_value;
    logic [1:0]  slot_hit;
    logic [1:0]  expired_mask;
    logic [1:0]  active_mask;

    modport source (output valid, status, sensor_address, pitch_bits, roll_bits,
                    range_value, slot_hit, expired_mask, active_mask, input ready);
    modport sink (input valid, status, sensor_address, pitch_bits, roll_bits,
                  range_value, slot_hit, expired_mask, active_mask, output ready);
endinterface

/* rtl/core/sensor_frame_receiver_with_timeout.sv */
// Top level of the sensor frame receiver: configuration registers and the three stages.
//
//   Channel   Direction  Carries
//   item      in         action, rx_byte, now_ms
//   result    out        status, frame fields, slot_hit, expired_mask, active_mask
//   cfg_*     in         register writes, index 0 to 4
//
// One word is taken per cycle while item.ready is high; each yields one result word, passing
// through the command queue register and then the result register of the slot engine.
// Reset clears the store position, the queue, the slot stamps and the result valid flag;
// it needs no clearing pass.
// The queue and the result register together hold three words before item.ready falls.
module sensor_frame_receiver_with_timeout #(
    parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH,
    parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sfr_item_if.sink                        item,
    sfr_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sfr_pkg::cfg_t        cfg_reg;
    sfr_pkg::cmd_t        front_cmd;
    sfr_pkg::cmd_t        head_cmd;
    sfr_pkg::queue_stat_t qstat;
    logic                 take;
    logic                 pop;

    assign item.ready = !qstat.full;
    assign take       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte         <= sfr_pkg::RESET_HEADER;
            cfg_reg.footer_byte         <= sfr_pkg::RESET_FOOTER;
            cfg_reg.first_slot_address  <= sfr_pkg::RESET_FIRST;
            cfg_reg.second_slot_address <= sfr_pkg::RESET_SECOND;
            cfg_reg.timeout_limit       <= sfr_pkg::RESET_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_HEADER:  cfg_reg.header_byte         <= cfg_data[7:0];
                sfr_pkg::CFG_FOOTER:  cfg_reg.footer_byte         <= cfg_data[7:0];
                sfr_pkg::CFG_FIRST:   cfg_reg.first_slot_address  <= cfg_data[15:0];
                sfr_pkg::CFG_SECOND:  cfg_reg.second_slot_address <= cfg_data[15:0];
                sfr_pkg::CFG_TIMEOUT: cfg_reg.timeout_limit       <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    sfr_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .action  (item.action),
        .rx_byte (item.rx_byte),
        .now_ms  (item.now_ms),
        .cfg     (cfg_reg),
        .cmd     (front_cmd)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .stat     (qstat)
    );

    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (!qstat.empty),
        .cfg       (cfg_reg),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* rtl/core/sfr_front.sv */
// Front end: tracks the store position, keeps the inspected frame bytes and classifies words.
module sfr_front #(
    parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic          action,
    input  logic [7:0]    rx_byte,
    input  logic [31:0]   now_ms,
    input  sfr_pkg::cfg_t cfg,
    output sfr_pkg::cmd_t cmd
);

    localparam int POS_W = $clog2(STORE_DEPTH);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       byte_reg [sfr_pkg::FRAME_BYTES];
    logic [7:0]       fb [sfr_pkg::FRAME_BYTES];
    logic             is_footer;
    logic             structural_drop;
    logic [15:0]      addr;
    logic [31:0]      pitch;
    logic [31:0]      roll;
    logic [7:0]       rng;

    // The word being taken is already part of the frame it may close.
    always_comb
    begin
        for (int i = 0; i < sfr_pkg::FRAME_BYTES; i++)
        begin
            fb[i] = (pos_reg == POS_W'(i)) ? rx_byte : byte_reg[i];
        end
    end

    assign is_footer = (rx_byte == cfg.footer_byte);
    assign structural_drop = (fb[0] != cfg.header_byte) || (fb[1] != sfr_pkg::LEN_CODE)
                          || (pos_reg < POS_W'(sfr_pkg::FRAME_BYTES - 1));
    assign addr  = {fb[5], fb[4]};
    assign pitch = {fb[9], fb[8], fb[7], fb[6]};
    assign roll  = {fb[13], fb[12], fb[11], fb[10]};
    assign rng   = fb[14];

    always_comb
    begin
        cmd = '0;
        cmd.now_ms = now_ms;
        if (action)
        begin
            cmd.kind = sfr_pkg::CMD_TIMEOUT;
        end
        else if (!is_footer)
        begin
            cmd.kind = sfr_pkg::CMD_BYTE;
        end
        else if (structural_drop)
        begin
            cmd.kind = sfr_pkg::CMD_DROP;
        end
        else
        begin
            cmd.sensor_address = addr;
            cmd.pitch_bits     = pitch;
            cmd.roll_bits      = roll;
            cmd.range_value    = rng;
            if (sfr_pkg::angle_ok(pitch) && sfr_pkg::angle_ok(roll) && (rng != 8'd0))
            begin
                cmd.kind = sfr_pkg::CMD_ACCEPT;
            end
            else
            begin
                cmd.kind = sfr_pkg::CMD_REJECT;
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (take && !action)
        begin
            if (is_footer || (pos_reg == POS_W'(STORE_DEPTH - 1)))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !action)
        begin
            for (int i = 0; i < sfr_pkg::FRAME_BYTES; i++)
            begin
                if (pos_reg == POS_W'(i))
                begin
                    byte_reg[i] <= rx_byte;
                end
            end
        end
    end

endmodule

/* rtl/core/sfr_queue.sv */
// Short command queue between the front end and the slot engine.
module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfr_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output sfr_pkg::cmd_t        head,
    output sfr_pkg::queue_stat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/sfr_back.sv */
// Slot engine: keeps the slot stamps, runs timeout checks and registers the result word.
module sfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sfr_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    input  sfr_pkg::cfg_t cfg,
    output logic          pop,
    sfr_result_if.source  result
);

    logic        out_valid_reg;
    logic [31:0] stamp_reg [2];
    logic [31:0] stamp_next [2];
    logic [31:0] age [2];
    logic [1:0]  expired;
    logic [1:0]  hit;
    logic [1:0]  status;
    logic        load;

    logic [1:0]  status_reg;
    logic [15:0] addr_reg;
    logic [31:0] pitch_reg;
    logic [31:0] roll_reg;
    logic [7:0]  range_reg;
    logic [1:0]  hit_reg;
    logic [1:0]  expired_reg;
    logic [1:0]  active_reg;

    assign load = !out_valid_reg || result.ready;
    assign pop  = cmd_valid && load;

    always_comb
    begin
        hit = sfr_pkg::SLOT_NONE;
        if (cmd.kind == sfr_pkg::CMD_ACCEPT)
        begin
            // Slot 0 wins when both slots carry the same address.
            if (cmd.sensor_address == cfg.first_slot_address)
            begin
                hit = sfr_pkg::SLOT_0;
            end
            else if (cmd.sensor_address == cfg.second_slot_address)
            begin
                hit = sfr_pkg::SLOT_1;
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            age[s] = cmd.now_ms - stamp_reg[s];
            expired[s] = (cmd.kind == sfr_pkg::CMD_TIMEOUT) && (stamp_reg[s] != 32'd0)
                      && (age[s] > cfg.timeout_limit);
            if (expired[s])
            begin
                stamp_next[s] = 32'd0;
            end
            else if (hit == 2'(s))
            begin
                stamp_next[s] = cmd.now_ms;
            end
            else
            begin
                stamp_next[s] = stamp_reg[s];
            end
        end
    end

    always_comb
    begin
        unique case (cmd.kind)
            sfr_pkg::CMD_DROP:   status = sfr_pkg::ST_DROP;
            sfr_pkg::CMD_REJECT: status = sfr_pkg::ST_VALUE_FAIL;
            sfr_pkg::CMD_ACCEPT: status = sfr_pkg::ST_ACCEPT;
            default:             status = sfr_pkg::ST_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            stamp_reg[0]  <= 32'd0;
            stamp_reg[1]  <= 32'd0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                stamp_reg[0]  <= stamp_next[0];
                stamp_reg[1]  <= stamp_next[1];
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= status;
            addr_reg    <= cmd.sensor_address;
            pitch_reg   <= cmd.pitch_bits;
            roll_reg    <= cmd.roll_bits;
            range_reg   <= cmd.range_value;
            hit_reg     <= hit;
            expired_reg <= expired;
            active_reg  <= {stamp_next[1] != 32'd0, stamp_next[0] != 32'd0};
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.sensor_address = addr_reg;
    assign result.pitch_bits     = pitch_reg;
    assign result.roll_bits      = roll_reg;
    assign result.range_value    = range_reg;
    assign result.slot_hit       = hit_reg;
    assign result.expired_mask   = expired_reg;
    assign result.active_mask    = active_reg;

endmodule
